// ===== rtl/core/mmss_pkg.sv =====
// ----------------------------------------------------------------------------
// mmss_pkg
// shared widths, limits and item types of the mark statistics unit
// ----------------------------------------------------------------------------
package mmss_pkg;

  localparam int MARK_W     = 14;
  localparam int CODE_W     = 17;
  localparam int YEAR_W     = 3;
  localparam int OUT_W      = 14;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 24;
  localparam int SQ_W       = 37;

  localparam int MAX_ITEMS  = 1024;
  localparam int MARK_MAX   = 10000;
  localparam int YEAR_FIRST = 1;
  localparam int YEAR_LAST  = 4;
  localparam int CODE_DIGITS = 6;

  localparam int MUL_W      = 24;
  localparam int WIDE_W     = 48;
  localparam int SPLIT      = 19;
  localparam int DEN_W      = 21;
  localparam int REM_W      = 23;
  localparam int ROOT_W     = 16;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int DIV_STEPS  = WIDE_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [CODE_W-1:0] subject_code;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] std_dev;
    logic [OUT_W-1:0] std_error;
    logic [CNT_W-1:0] kept_count;
    logic             overflow;
  } out_item_t;

endpackage

// ===== rtl/core/mark_mean_stddev_stderr_unit.sv =====
// ----------------------------------------------------------------------------
// mark_mean_stddev_stderr_unit
// mean, sample standard deviation and standard error of a set of marks
// ----------------------------------------------------------------------------
// Input items (mark, course code, last) arrive on the in channel under
// valid/stall. While idle the unit takes one item per cycle; each kept item
// is added to the count, sum and sum of squares in the cycle after acceptance.
// An item is kept when year_select is 1 to 4 and the leading decimal digit of
// its course code matches, or always when year_select is any other value.
// Kept items beyond 1024 are dropped and flagged.
// The item marked last closes the set: in_stall rises and one shared
// multiplier plus one shared subtractor, under a small sequencer, work out
// the result. Mean: 48 divider steps. Deviation and error add the multiply
// and difference states MUL_LO, MUL_HI, MUL_SQ, DIFF and MUL_NN1, three more
// 48-step divisions and two 16-step roots. The result is offered with no step
// for an empty set, after the mean only for a single item, else after all.
// The result waits in an output register; while the receiver stalls it
// holds, and the unit stays stalled until it can load the next result.
// Synchronous reset clears the sums, the year register and both valids.
// Users write year_select by cfg_we/cfg_wdata only when idle; not enforced.
// ----------------------------------------------------------------------------
module mark_mean_stddev_stderr_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mmss_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mmss_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [mmss_pkg::YEAR_W-1:0]   cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_START,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SQ,
    ST_DIFF,
    ST_MUL_NN1,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    JOB_MEAN,
    JOB_SD_VAR,
    JOB_SD_ROOT,
    JOB_SE_Q,
    JOB_SE_VAR,
    JOB_SE_ROOT
  } job_t;

  state_t                          state;
  job_t                            job;
  logic [mmss_pkg::YEAR_W-1:0]     year_select;

  logic                            p_valid;
  logic                            p_pass;
  logic [mmss_pkg::MARK_W-1:0]     p_mark;

  logic [mmss_pkg::CNT_W-1:0]      item_count;
  logic [mmss_pkg::SUM_W-1:0]      mark_sum;
  logic [mmss_pkg::SQ_W-1:0]       square_sum;
  logic                            dropped_flag;

  logic [mmss_pkg::WIDE_W-1:0]     wide_a;
  logic [mmss_pkg::WIDE_W-1:0]     wide_b;
  logic [mmss_pkg::DEN_W-1:0]      nn1;
  logic [mmss_pkg::WIDE_W-1:0]     num;
  logic [mmss_pkg::DEN_W-1:0]      den;
  logic [mmss_pkg::REM_W-1:0]      rem;
  logic [mmss_pkg::WIDE_W-1:0]     quo;
  logic [mmss_pkg::STEP_W-1:0]     step;

  logic [mmss_pkg::OUT_W-1:0]      mean_r;
  logic [mmss_pkg::OUT_W-1:0]      sd_r;
  logic [mmss_pkg::OUT_W-1:0]      se_r;

  logic                            in_accept;
  logic                            out_load;
  logic [mmss_pkg::MARK_W-1:0]     mark_sat;
  logic                            pass;

  logic [mmss_pkg::MUL_W-1:0]      mul_a;
  logic [mmss_pkg::MUL_W-1:0]      mul_b;
  logic [mmss_pkg::WIDE_W-1:0]     mul_p;

  logic [mmss_pkg::REM_W-1:0]      div_sh;
  logic [mmss_pkg::REM_W-1:0]      sqrt_sh;
  logic [mmss_pkg::WIDE_W-1:0]     sub_a;
  logic [mmss_pkg::WIDE_W-1:0]     sub_b;
  logic [mmss_pkg::WIDE_W:0]       sub_full;
  logic                            borrow;
  logic [mmss_pkg::REM_W-1:0]      rem_next;
  logic [mmss_pkg::WIDE_W-1:0]     quo_next;
  logic [mmss_pkg::ROOT_W:0]       root_inc;
  logic [mmss_pkg::OUT_W-1:0]      root_round;
  logic [mmss_pkg::WIDE_W-1:0]     four_d;
  logic                            div_last;
  logic                            sqrt_last;

  function automatic logic year_match(input logic [mmss_pkg::CODE_W-1:0] code,
                                      input logic [mmss_pkg::YEAR_W-1:0] yr);
    logic hit;
    int   p;
    hit = 1'b0;
    for (int y = mmss_pkg::YEAR_FIRST; y <= mmss_pkg::YEAR_LAST; y++) begin
      p = 1;
      for (int k = 0; k < mmss_pkg::CODE_DIGITS; k++) begin
        if (yr == mmss_pkg::YEAR_W'(y) && 32'(code) >= y * p &&
            32'(code) < (y + 1) * p) begin
          hit = 1'b1;
        end
        p = p * 10;
      end
    end
    return hit;
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  assign mark_sat = (in_data.mark > mmss_pkg::MARK_W'(mmss_pkg::MARK_MAX)) ?
                    mmss_pkg::MARK_W'(mmss_pkg::MARK_MAX) : in_data.mark;

  assign pass = (year_select >= mmss_pkg::YEAR_W'(mmss_pkg::YEAR_FIRST) &&
                 year_select <= mmss_pkg::YEAR_W'(mmss_pkg::YEAR_LAST)) ?
                year_match(in_data.subject_code, year_select) : 1'b1;

  // shared multiplier
  always_comb begin
    case (state)
      ST_MUL_LO: begin
        mul_a = mmss_pkg::MUL_W'(item_count);
        mul_b = mmss_pkg::MUL_W'(square_sum[mmss_pkg::SPLIT-1:0]);
      end
      ST_MUL_HI: begin
        mul_a = mmss_pkg::MUL_W'(item_count);
        mul_b = mmss_pkg::MUL_W'(square_sum[mmss_pkg::SQ_W-1:mmss_pkg::SPLIT]);
      end
      ST_MUL_SQ: begin
        mul_a = mark_sum;
        mul_b = mark_sum;
      end
      ST_MUL_NN1: begin
        mul_a = mmss_pkg::MUL_W'(item_count);
        mul_b = mmss_pkg::MUL_W'(item_count - mmss_pkg::CNT_W'(1));
      end
      default: begin
        mul_a = mmss_pkg::MUL_W'(p_mark);
        mul_b = mmss_pkg::MUL_W'(p_mark);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared subtractor for the difference, divider and root steps
  assign div_sh  = {rem[mmss_pkg::REM_W-2:0], num[mmss_pkg::WIDE_W-1]};
  assign sqrt_sh = {rem[mmss_pkg::REM_W-3:0], num[mmss_pkg::WIDE_W-1 -: 2]};

  always_comb begin
    case (state)
      ST_DIFF: begin
        sub_a = wide_a;
        sub_b = wide_b;
      end
      ST_SQRT: begin
        sub_a = mmss_pkg::WIDE_W'(sqrt_sh);
        sub_b = mmss_pkg::WIDE_W'({quo[mmss_pkg::ROOT_W-1:0], 2'b01});
      end
      default: begin
        sub_a = mmss_pkg::WIDE_W'(div_sh);
        sub_b = mmss_pkg::WIDE_W'(den);
      end
    endcase
  end

  assign sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow     = sub_full[mmss_pkg::WIDE_W];
  assign rem_next   = borrow ? sub_a[mmss_pkg::REM_W-1:0] : sub_full[mmss_pkg::REM_W-1:0];
  assign quo_next   = {quo[mmss_pkg::WIDE_W-2:0], ~borrow};
  assign root_inc   = {1'b0, quo_next[mmss_pkg::ROOT_W-1:0]} + (mmss_pkg::ROOT_W+1)'(1);
  assign root_round = root_inc[mmss_pkg::OUT_W:1];
  assign four_d     = {wide_a[mmss_pkg::WIDE_W-3:0], 2'b00};
  assign div_last   = (step == mmss_pkg::STEP_W'(mmss_pkg::DIV_STEPS - 1));
  assign sqrt_last  = (step == mmss_pkg::STEP_W'(mmss_pkg::SQRT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      job          <= JOB_MEAN;
      year_select  <= '0;
      p_valid      <= 1'b0;
      item_count   <= '0;
      mark_sum     <= '0;
      square_sum   <= '0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
      step         <= '0;
    end else begin
      if (cfg_we) begin
        year_select <= cfg_wdata;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // capture stage
      p_valid <= in_accept;
      if (in_accept) begin
        p_mark <= mark_sat;
        p_pass <= pass;
      end

      // accumulate the captured item
      if (p_valid && p_pass) begin
        if (item_count < mmss_pkg::CNT_W'(mmss_pkg::MAX_ITEMS)) begin
          item_count <= item_count + mmss_pkg::CNT_W'(1);
          mark_sum   <= mark_sum + mmss_pkg::SUM_W'(p_mark);
          square_sum <= square_sum + mmss_pkg::SQ_W'(mul_p);
        end else begin
          dropped_flag <= 1'b1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_accept && in_data.last) begin
            state <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          state <= ST_START;
        end

        ST_START: begin
          mean_r <= '0;
          sd_r   <= '0;
          se_r   <= '0;
          if (item_count == '0) begin
            state <= ST_OUT;
          end else begin
            num   <= mmss_pkg::WIDE_W'({mark_sum, 1'b0}) + mmss_pkg::WIDE_W'(item_count);
            den   <= mmss_pkg::DEN_W'({item_count, 1'b0});
            rem   <= '0;
            quo   <= '0;
            step  <= '0;
            job   <= JOB_MEAN;
            state <= ST_DIV;
          end
        end

        ST_MUL_LO: begin
          wide_a <= mul_p;
          state  <= ST_MUL_HI;
        end

        ST_MUL_HI: begin
          wide_a <= wide_a + (mul_p << mmss_pkg::SPLIT);
          state  <= ST_MUL_SQ;
        end

        ST_MUL_SQ: begin
          wide_b <= mul_p;
          state  <= ST_DIFF;
        end

        ST_DIFF: begin
          wide_a <= borrow ? '0 : sub_full[mmss_pkg::WIDE_W-1:0];
          state  <= ST_MUL_NN1;
        end

        ST_MUL_NN1: begin
          nn1   <= mul_p[mmss_pkg::DEN_W-1:0];
          den   <= mul_p[mmss_pkg::DEN_W-1:0];
          num   <= four_d;
          rem   <= '0;
          quo   <= '0;
          step  <= '0;
          job   <= JOB_SD_VAR;
          state <= ST_DIV;
        end

        ST_DIV: begin
          if (div_last) begin
            rem  <= '0;
            quo  <= '0;
            step <= '0;
            case (job)
              JOB_MEAN: begin
                mean_r <= quo_next[mmss_pkg::OUT_W-1:0];
                state  <= (item_count < mmss_pkg::CNT_W'(2)) ? ST_OUT : ST_MUL_LO;
              end
              JOB_SD_VAR: begin
                num   <= {quo_next[mmss_pkg::RAD_W-1:0],
                          (mmss_pkg::WIDE_W - mmss_pkg::RAD_W)'(0)};
                job   <= JOB_SD_ROOT;
                state <= ST_SQRT;
              end
              JOB_SE_Q: begin
                num <= quo_next;
                den <= nn1;
                job <= JOB_SE_VAR;
              end
              JOB_SE_VAR: begin
                num   <= {quo_next[mmss_pkg::RAD_W-1:0],
                          (mmss_pkg::WIDE_W - mmss_pkg::RAD_W)'(0)};
                job   <= JOB_SE_ROOT;
                state <= ST_SQRT;
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end else begin
            rem  <= rem_next;
            quo  <= quo_next;
            num  <= {num[mmss_pkg::WIDE_W-2:0], 1'b0};
            step <= step + mmss_pkg::STEP_W'(1);
          end
        end

        ST_SQRT: begin
          if (sqrt_last) begin
            rem  <= '0;
            quo  <= '0;
            step <= '0;
            if (job == JOB_SD_ROOT) begin
              sd_r <= root_round;
              num  <= four_d;
              den  <= mmss_pkg::DEN_W'(item_count);
              job  <= JOB_SE_Q;
              state <= ST_DIV;
            end else begin
              se_r  <= root_round;
              state <= ST_OUT;
            end
          end else begin
            rem  <= rem_next;
            quo  <= quo_next;
            num  <= {num[mmss_pkg::WIDE_W-3:0], 2'b00};
            step <= step + mmss_pkg::STEP_W'(1);
          end
        end

        ST_OUT: begin
          if (out_load) begin
            out_data.mean       <= mean_r;
            out_data.std_dev    <= sd_r;
            out_data.std_error  <= se_r;
            out_data.kept_count <= item_count;
            out_data.overflow   <= dropped_flag;
            item_count          <= '0;
            mark_sum            <= '0;
            square_sum          <= '0;
            dropped_flag        <= 1'b0;
            state               <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
